// ===== rtl/rc_differential_drive_mixer_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the drive mixer
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RC_DIFFERENTIAL_DRIVE_MIXER_TOP_ASSERT_SVH
`define RC_DIFFERENTIAL_DRIVE_MIXER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RCDM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcdm check failed");
`define RCDM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcdm check failed");
`else
`define RCDM_ASSERT_IMP(lbl, ante, cons)
`define RCDM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/rcdm_pkg.sv =====
// ----------------------------------------------------------------------------
// rcdm_pkg
// Shared widths, codes and types of the differential drive mixer.
// ----------------------------------------------------------------------------
package rcdm_pkg;

  localparam int PULSE_W    = 16;
  localparam int DIVD_W     = 23;
  localparam int DIVR_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MUL_STEPS  = 15;

  localparam logic [15:0] LOW_PULSE_RST  = 16'd14970;
  localparam logic [15:0] HIGH_PULSE_RST = 16'd27530;
  localparam logic [14:0] DEAD_BAND_RST  = 15'd10;
  localparam logic [14:0] PIVOT_LVL_RST  = 15'd15;
  localparam logic [7:0]  TRACK_PCT_RST  = 8'd100;
  localparam logic [7:0]  DUTY_LIM_RST   = 8'd249;

  localparam logic [DIVR_W-1:0] FULL16 = 16'hFFFF;
  localparam logic [DIVR_W-1:0] FULL8  = 16'd255;

  typedef enum logic [3:0] {
    S_IDLE, S_GAIN, S_OFFS, S_STEER, S_THRUST, S_Q1, S_MUL1, S_Q2, S_MUL2, S_OUT
  } rcdm_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_PULSE  = 3'd0,
    REG_HIGH_PULSE = 3'd1,
    REG_DEAD_BAND  = 3'd2,
    REG_PIVOT_LVL  = 3'd3,
    REG_TRACK_PCT  = 3'd4,
    REG_DUTY_LIM   = 3'd5
  } rcdm_reg_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVR_W-1:0] divisor;
  } rcdm_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } rcdm_div_rsp_t;

endpackage

// ===== rtl/rcdm_if.sv =====
// ----------------------------------------------------------------------------
// rcdm channel interfaces
// Valid/ready channels for pulse beats, drive beats and register writes.
// ----------------------------------------------------------------------------
interface rcdm_in_if;
  import rcdm_pkg::*;
  logic               valid;
  logic               ready;
  logic [PULSE_W-1:0] steer_pulse;
  logic [PULSE_W-1:0] thrust_pulse;
  logic               link_active;
  modport source (output valid, steer_pulse, thrust_pulse, link_active, input ready);
  modport sink   (input valid, steer_pulse, thrust_pulse, link_active, output ready);
endinterface

interface rcdm_out_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] port_drive;
  logic signed [8:0] starboard_drive;
  logic              relay_closed;
  logic              led_on;
  modport source (output valid, port_drive, starboard_drive, relay_closed, led_on,
                  input ready);
  modport sink   (input valid, port_drive, starboard_drive, relay_closed, led_on,
                  output ready);
endinterface

interface rcdm_cfg_if;
  import rcdm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/rcdm_div.sv =====
// ----------------------------------------------------------------------------
// rcdm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcdm_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rcdm_pkg::rcdm_div_req_t req,
  output rcdm_pkg::rcdm_div_rsp_t rsp
);
  import rcdm_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVD_W-1:0] quo_r;
  logic [DIVR_W-1:0] rem_r;
  logic [DIVR_W-1:0] divr_r;

  logic [DIVR_W:0]   trial;
  logic [DIVR_W:0]   diff;
  logic              ge;
  logic [DIVR_W-1:0] rem_nxt;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    trial   = {rem_r, quo_r[DIVD_W-1]};
    diff    = trial - {1'b0, divr_r};
    ge      = trial >= {1'b0, divr_r};
    rem_nxt = ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
  end

  // control: count the steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: load operands, then advance one bit a cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r  <= req.dividend;
      rem_r  <= '0;
      divr_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== rtl/rc_differential_drive_mixer_top.sv =====
// ----------------------------------------------------------------------------
// rc_differential_drive_mixer_top
// Scales steer and thrust pulse widths, applies deadband, mixes them into
// port and starboard drive values with pivot lock and a duty limit.
// ----------------------------------------------------------------------------
// Each input beat is worked through six passes of the shared bit-serial
// divider and two shift-add multiplies; a new input beat is taken only once
// the sequencer is back in S_IDLE.
// A new input beat is taken while the previous result waits in the output register.
// Reset: synchronous active-low rst_n clears pivot lock, the sequencer and
// restores every configuration register to its default; no clearing pass.
module rc_differential_drive_mixer_top (
  input logic        clk,
  input logic        rst_n,
  rcdm_in_if.sink    in_chan,
  rcdm_out_if.source out_chan,
  rcdm_cfg_if.sink   cfg_chan
);
  import rcdm_pkg::*;

  // configuration registers
  logic [15:0] low_r, high_r;
  logic [14:0] dead_r, pivot_lvl_r;
  logic [7:0]  track_r, duty_r;

  rcdm_state_t state_r, state_nxt;
  logic        run_r, run_nxt;
  logic        div_start;
  logic        pivot_r;
  logic [3:0]  mul_cnt_r;

  // item registers
  logic [15:0]        ws_r, wt_r;
  logic               link_r;
  logic [7:0]         gain_r;
  logic [DIVD_W-1:0]  offs_r;
  logic signed [15:0] steer_r, thrust_r;
  logic               rot_neg_r;
  logic [30:0]        mul_acc_r, mul_a_r;
  logic [14:0]        mul_b_r;

  // output register
  logic              out_valid_r;
  logic signed [8:0] port_r, stbd_r;
  logic              relay_r, led_r;

  rcdm_div_req_t div_req;
  rcdm_div_rsp_t div_rsp;

  logic in_take, out_load;

  rcdm_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign in_take  = in_chan.valid && in_chan.ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_chan.ready);

  // scale a divider result to signed 16 and apply the deadband
  logic [15:0]        w_sel;
  logic [DIVD_W-1:0]  dq;
  logic signed [15:0] sc, v, v_db;
  logic [16:0]        v_mag;

  always_comb begin
    w_sel = (state_r == S_THRUST) ? wt_r : ws_r;
    dq    = div_rsp.quotient - offs_r;
    if (dq[DIVD_W-1:16] != '0) sc = 16'sh7FFF;
    else                       sc = {~dq[15], dq[14:0]};
    if (!link_r)              v = '0;
    else if (w_sel > high_r)  v = 16'sh7FFF;
    else if (w_sel < low_r)   v = 16'sh8000;
    else if (gain_r == '0)    v = '0;
    else                      v = sc;
    v_mag = v[15] ? (~{1'b1, v} + 17'd1) : {1'b0, v};
    v_db  = (v_mag <= {2'b00, dead_r}) ? 16'sd0 : v;
  end

  // magnitudes of the stored values and the first mixing product
  logic [16:0] s_mag, t_mag;
  logic [23:0] m1;
  logic        diff_neg;
  logic [15:0] diff_mag;

  always_comb begin
    s_mag    = steer_r[15]  ? (~{1'b1, steer_r}  + 17'd1) : {1'b0, steer_r};
    t_mag    = thrust_r[15] ? (~{1'b1, thrust_r} + 17'd1) : {1'b0, thrust_r};
    m1       = mul_acc_r[30:7];
    diff_neg = thrust_r[15] ^ steer_r[15];
    if (diff_neg) diff_mag = (m1 > 24'd32768) ? 16'd32768 : m1[15:0];
    else          diff_mag = (m1 > 24'd32767) ? 16'd32767 : m1[15:0];
  end

  // divider operand select
  always_comb begin
    div_req.start    = div_start;
    div_req.dividend = '0;
    div_req.divisor  = FULL8;
    case (state_r)
      S_GAIN: begin
        div_req.dividend = {high_r - low_r, 7'd0};
        div_req.divisor  = FULL16;
      end
      S_OFFS: begin
        div_req.dividend = {low_r, 7'd0};
        div_req.divisor  = {8'd0, gain_r};
      end
      S_STEER: begin
        div_req.dividend = {ws_r, 7'd0};
        div_req.divisor  = {8'd0, gain_r};
      end
      S_THRUST: begin
        div_req.dividend = {wt_r, 7'd0};
        div_req.divisor  = {8'd0, gain_r};
      end
      S_Q1:    div_req.dividend = {s_mag[15:0], 7'd0};
      S_Q2:    div_req.dividend = {diff_mag, 7'd0};
      default: div_req.dividend = '0;
    endcase
  end

  // final mix and duty limit
  logic signed [17:0] th18, st18, rot18, pa, pb, dl, ndl, lp, lb;
  logic               mix;
  logic [15:0]        rot_mag;

  always_comb begin
    rot_mag = mul_acc_r[22:7];
    th18    = 18'(thrust_r);
    st18    = 18'(steer_r);
    rot18   = rot_neg_r ? -$signed({2'b00, rot_mag}) : $signed({2'b00, rot_mag});
    mix     = (thrust_r != '0) && !pivot_r;
    pa      = mix ? th18 - rot18 : st18;
    pb      = mix ? th18 + rot18 : -st18;
    dl      = $signed({10'd0, duty_r});
    ndl     = -dl;
    lp      = (pa > dl) ? dl : ((pa < ndl) ? ndl : pa);
    lb      = (pb > dl) ? dl : ((pb < ndl) ? ndl : pb);
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    run_nxt   = run_r;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_take) state_nxt = S_GAIN;
      S_GAIN, S_OFFS, S_STEER, S_THRUST, S_Q1, S_Q2: begin
        if (!run_r) begin
          div_start = 1'b1;
          run_nxt   = 1'b1;
        end else if (div_rsp.done) begin
          run_nxt = 1'b0;
          case (state_r)
            S_GAIN:   state_nxt = S_OFFS;
            S_OFFS:   state_nxt = S_STEER;
            S_STEER:  state_nxt = S_THRUST;
            S_THRUST: state_nxt = S_Q1;
            S_Q1:     state_nxt = S_MUL1;
            default:  state_nxt = S_MUL2;
          endcase
        end
      end
      S_MUL1: if (mul_cnt_r == 4'(MUL_STEPS - 1)) state_nxt = S_Q2;
      S_MUL2: if (mul_cnt_r == 4'(MUL_STEPS - 1)) state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_r       <= 1'b0;
      pivot_r     <= 1'b0;
      mul_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      low_r       <= LOW_PULSE_RST;
      high_r      <= HIGH_PULSE_RST;
      dead_r      <= DEAD_BAND_RST;
      pivot_lvl_r <= PIVOT_LVL_RST;
      track_r     <= TRACK_PCT_RST;
      duty_r      <= DUTY_LIM_RST;
    end else begin
      state_r <= state_nxt;
      run_r   <= run_nxt;
      if ((state_r == S_Q1 || state_r == S_Q2) && div_rsp.done) mul_cnt_r <= '0;
      else if (state_r == S_MUL1 || state_r == S_MUL2) mul_cnt_r <= mul_cnt_r + 4'd1;
      if (out_load) begin
        out_valid_r <= 1'b1;
        if (!mix) pivot_r <= s_mag > {2'b00, pivot_lvl_r};
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      // register writes
      if (cfg_chan.valid && cfg_chan.ready) begin
        unique case (cfg_chan.index)
          REG_LOW_PULSE:  low_r       <= cfg_chan.data;
          REG_HIGH_PULSE: high_r      <= cfg_chan.data;
          REG_DEAD_BAND:  dead_r      <= cfg_chan.data[14:0];
          REG_PIVOT_LVL:  pivot_lvl_r <= cfg_chan.data[14:0];
          REG_TRACK_PCT:  track_r     <= cfg_chan.data[7:0];
          REG_DUTY_LIM:   duty_r      <= cfg_chan.data[7:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      ws_r   <= in_chan.steer_pulse;
      wt_r   <= in_chan.thrust_pulse;
      link_r <= in_chan.link_active;
    end
    if (div_rsp.done) begin
      case (state_r)
        S_GAIN:   gain_r   <= div_rsp.quotient[7:0];
        S_OFFS:   offs_r   <= div_rsp.quotient;
        S_STEER:  steer_r  <= v_db;
        S_THRUST: thrust_r <= v_db;
        S_Q1: begin
          mul_acc_r <= '0;
          mul_a_r   <= {15'd0, t_mag[15:0]};
          mul_b_r   <= div_rsp.quotient[14:0];
        end
        S_Q2: begin
          rot_neg_r <= diff_neg;
          mul_acc_r <= '0;
          mul_a_r   <= {23'd0, track_r};
          mul_b_r   <= div_rsp.quotient[14:0];
        end
        default: ;
      endcase
    end
    // shift-add one multiplier bit a cycle
    if (state_r == S_MUL1 || state_r == S_MUL2) begin
      if (mul_b_r[0]) mul_acc_r <= mul_acc_r + mul_a_r;
      mul_a_r <= {mul_a_r[29:0], 1'b0};
      mul_b_r <= {1'b0, mul_b_r[14:1]};
    end
    if (out_load) begin
      port_r  <= lp[8:0];
      stbd_r  <= lb[8:0];
      relay_r <= (lp != '0) || (lb != '0);
      led_r   <= (lp == '0) && (lb == '0);
    end
  end

  assign in_chan.ready            = (state_r == S_IDLE);
  assign cfg_chan.ready           = 1'b1;
  assign out_chan.valid           = out_valid_r;
  assign out_chan.port_drive      = port_r;
  assign out_chan.starboard_drive = stbd_r;
  assign out_chan.relay_closed    = relay_r;
  assign out_chan.led_on          = led_r;

`include "rc_differential_drive_mixer_top_assert.svh"

  // a result beat is always presented after the final step
  `RCDM_ASSERT_NXT(a_out_load, (state_r == S_OUT) && !out_valid_r, out_valid_r)
  // drives never exceed the duty limit
  `RCDM_ASSERT_IMP(a_port_lim, out_valid_r, (port_r <= $signed({1'b0, duty_r})) && (port_r >= -$signed({1'b0, duty_r})))
  `RCDM_ASSERT_IMP(a_stbd_lim, out_valid_r, (stbd_r <= $signed({1'b0, duty_r})) && (stbd_r >= -$signed({1'b0, duty_r})))
  // relay and LED flags are complementary
  `RCDM_ASSERT_IMP(a_flags, out_valid_r, relay_r != led_r)
  // divider only finishes for a pass that was started
  `RCDM_ASSERT_IMP(a_div_done, div_rsp.done, run_r)

endmodule

// ===== verif/rc_differential_drive_mixer_top_test.sv =====
// ----------------------------------------------------------------------------
// Drive mixer block test
// Feeds pulse-width beats through a bursty source into the mixer, predicts
// every drive beat with an in-bench scaler and mixer, and compares each
// result field by field. Register settings cycle through reset defaults,
// extremes, narrow and inverted windows, and random windows.
// ----------------------------------------------------------------------------
module rc_differential_drive_mixer_top_test;
  import rcdm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                   CYCLE_LIMIT = 1000000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd6;

  typedef struct {
    logic [15:0] steer;
    logic [15:0] thrust;
    logic        link;
  } pulse_beat_t;

  typedef struct {
    logic signed [8:0] port;
    logic signed [8:0] stbd;
    logic              relay;
    logic              led;
  } drive_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rcdm_in_if  in_chan ();
  rcdm_out_if out_chan ();
  rcdm_cfg_if cfg_chan ();

  rc_differential_drive_mixer_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Shadow registers and pivot state of the predictor
  logic [15:0] lo_pulse, hi_pulse;
  logic [14:0] band, pivot_lvl;
  logic [7:0]  track_pct, duty_lim;
  logic        pivot_held;

  pulse_beat_t pending_q[$];
  drive_beat_t drive_exp_q[$];
  int          beats_queued, beats_taken, drives_seen, mismatch_cnt, cycle_cnt;
  int          burst_left, gap_left, stall_left, open_left, phase_cnt;

  // Clock
  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int width_to_level(logic [15:0] w);
    int gain;
    int offs;
    int v;
    if (w > hi_pulse) return 32767;
    if (w < lo_pulse) return -32768;
    gain = (128 * (int'(hi_pulse) - int'(lo_pulse))) / 65535;
    if (gain == 0) return 0;
    offs = (128 * int'(lo_pulse)) / gain + 32768;
    v = (128 * int'(w)) / gain - offs;
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic int sat_level(int v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic int duty_clamp(int v);
    int m;
    m = int'(duty_lim);
    return v > m ? m : (v < -m ? -m : v);
  endfunction

  // Mix one pulse beat into drives; updates the pivot state
  function automatic drive_beat_t mix_drive(pulse_beat_t b);
    drive_beat_t r;
    int steer;
    int thrust;
    int diff;
    int rot;
    int p;
    int s;
    steer = 0;
    thrust = 0;
    if (b.link) begin
      steer = width_to_level(b.steer);
      thrust = width_to_level(b.thrust);
    end
    if ((steer < 0 ? -steer : steer) <= int'(band)) steer = 0;
    if ((thrust < 0 ? -thrust : thrust) <= int'(band)) thrust = 0;
    if (thrust != 0 && !pivot_held) begin
      diff = sat_level((thrust * ((128 * steer) / 255)) / 128);
      rot = sat_level((int'(track_pct) * ((128 * diff) / 255)) / 128);
      p = duty_clamp(thrust - rot);
      s = duty_clamp(thrust + rot);
    end else begin
      pivot_held = (steer < 0 ? -steer : steer) > int'(pivot_lvl);
      p = duty_clamp(steer);
      s = duty_clamp(-steer);
    end
    r.port = p[8:0];
    r.stbd = s[8:0];
    r.relay = (p != 0 || s != 0);
    r.led = (p == 0 && s == 0);
    return r;
  endfunction

  // Driver: record accepted beats, then present the next one in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        drive_exp_q.push_back(mix_drive('{in_chan.steer_pulse, in_chan.thrust_pulse,
                                          in_chan.link_active}));
        beats_taken++;
      end
      if (!(in_chan.valid && !in_chan.ready)) begin
        if (gap_left > 0) begin
          in_chan.valid <= 1'b0;
          gap_left--;
        end else if (pending_q.size() > 0) begin
          in_chan.valid        <= 1'b1;
          in_chan.steer_pulse  <= pending_q[0].steer;
          in_chan.thrust_pulse <= pending_q[0].thrust;
          in_chan.link_active  <= pending_q[0].link;
          void'(pending_q.pop_front());
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall on a pattern of open and closed runs, check each beat
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        drives_seen++;
        if (drive_exp_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected drive beat: port %0d stbd %0d", out_chan.port_drive,
                     out_chan.starboard_drive);
        end else begin
          if (out_chan.port_drive !== drive_exp_q[0].port ||
              out_chan.starboard_drive !== drive_exp_q[0].stbd ||
              out_chan.relay_closed !== drive_exp_q[0].relay ||
              out_chan.led_on !== drive_exp_q[0].led) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("drive mismatch: exp port %0d stbd %0d relay %0b led %0b, got port %0d stbd %0d relay %0b led %0b",
                       drive_exp_q[0].port, drive_exp_q[0].stbd, drive_exp_q[0].relay,
                       drive_exp_q[0].led, out_chan.port_drive, out_chan.starboard_drive,
                       out_chan.relay_closed, out_chan.led_on);
          end
          void'(drive_exp_q.pop_front());
        end
      end
      if (open_left > 0) begin
        out_chan.ready <= 1'b1;
        open_left--;
      end else if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
        open_left = $urandom_range(1, 400);
        stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 250);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

  // Write one register; valid stays high for a following write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk); while (!cfg_chan.ready);
    case (idx)
      REG_LOW_PULSE:  lo_pulse = val;
      REG_HIGH_PULSE: hi_pulse = val;
      REG_DEAD_BAND:  band = val[14:0];
      REG_PIVOT_LVL:  pivot_lvl = val[14:0];
      REG_TRACK_PCT:  track_pct = val[7:0];
      REG_DUTY_LIM:   duty_lim = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(logic [15:0] lo, logic [15:0] hi, logic [15:0] db,
                              logic [15:0] pl, logic [15:0] tp, logic [15:0] dl);
    write_reg(REG_LOW_PULSE, lo);
    write_reg(REG_HIGH_PULSE, hi);
    write_reg(REG_DEAD_BAND, db);
    write_reg(REG_PIVOT_LVL, pl);
    write_reg(REG_TRACK_PCT, tp);
    write_reg(REG_DUTY_LIM, dl);
    cfg_chan.valid <= 1'b0;
    phase_cnt++;
  endtask

  task automatic queue_beat(logic [15:0] s, logic [15:0] t, logic l);
    pending_q.push_back('{s, t, l});
    beats_queued++;
  endtask

  // Mostly near the pulse window, sometimes anywhere in the field range
  function automatic logic [15:0] pick_width();
    int w;
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    if ($urandom_range(0, 5) == 0) return 16'((17'(lo_pulse) + 17'(hi_pulse)) / 2);
    w = $urandom_range(int'(lo_pulse) > 300 ? int'(lo_pulse) - 300 : 0,
                       int'(hi_pulse) < 65235 ? int'(hi_pulse) + 300 : 65535);
    return w[15:0];
  endfunction

  task automatic queue_random(int n);
    for (int k = 0; k < n; k++)
      queue_beat(pick_width(),
                 ($urandom_range(0, 4) == 0) ? 16'((17'(lo_pulse) + 17'(hi_pulse)) / 2)
                                             : pick_width(),
                 $urandom_range(0, 9) != 0);
  endtask

  // Wait for all beats out and the block idle again
  task automatic drain();
    while (beats_taken < beats_queued || drive_exp_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Main sequence
  initial begin
    logic [15:0] lo;
    in_chan.valid = 1'b0;
    in_chan.steer_pulse = '0;
    in_chan.thrust_pulse = '0;
    in_chan.link_active = 1'b0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = REG_LOW_PULSE;
    cfg_chan.data = '0;
    lo_pulse = LOW_PULSE_RST;
    hi_pulse = HIGH_PULSE_RST;
    band = DEAD_BAND_RST;
    pivot_lvl = PIVOT_LVL_RST;
    track_pct = TRACK_PCT_RST;
    duty_lim = DUTY_LIM_RST;
    pivot_held = 1'b0;
    burst_left = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults: field extremes, window edges, pivot lock entry and release
    queue_beat(16'd0, 16'd0, 1'b1);
    queue_beat(16'hFFFF, 16'hFFFF, 1'b1);
    queue_beat(16'd14970, 16'd14970, 1'b1);
    queue_beat(16'd27530, 16'd27530, 1'b1);
    queue_beat(16'd14969, 16'd27531, 1'b1);
    queue_beat(16'd21250, 16'd21250, 1'b1);
    queue_beat(16'd21252, 16'd21250, 1'b1);
    queue_beat(16'd27530, 16'd21250, 1'b1);
    queue_beat(16'd21250, 16'd27530, 1'b1);
    queue_beat(16'd14970, 16'd14970, 1'b1);
    queue_beat(16'd21250, 16'd21250, 1'b1);
    queue_beat(16'd21250, 16'd27530, 1'b1);
    queue_beat(16'd24000, 16'd20000, 1'b1);
    queue_beat(16'hFFFF, 16'hFFFF, 1'b0);
    queue_beat(16'hAAAA, 16'h5555, 1'b1);
    queue_beat(16'h5555, 16'hAAAA, 1'b1);
    queue_beat(16'd18000, 16'd26000, 1'b1);
    queue_beat(16'd26000, 16'd16000, 1'b1);
    drain();

    // Full window, no dead band, widest mix and duty
    load_setting(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd255, 16'd255);
    queue_beat(16'd0, 16'hFFFF, 1'b1);
    queue_beat(16'h8000, 16'h8001, 1'b1);
    queue_random(30);
    drain();

    // Narrow window scales to zero inside; duty limit zero
    load_setting(16'd1000, 16'd1400, 16'd5, 16'd100, 16'd0, 16'd0);
    queue_random(25);
    drain();
    load_setting(16'd1000, 16'd1511, 16'd5, 16'd100, 16'd50, 16'd200);
    queue_random(25);
    drain();

    // Inverted window, maximum thresholds, and an ignored index
    write_reg(REG_UNUSED, 16'h1234);
    load_setting(16'd30000, 16'd20000, 16'h7FFF, 16'h7FFF, 16'd1, 16'd128);
    queue_random(25);
    drain();
    load_setting(16'd30000, 16'd20000, 16'd0, 16'd32767, 16'd1, 16'd128);
    queue_random(25);
    drain();

    // Random windows
    for (int ph = 0; ph < 6; ph++) begin
      lo = 16'($urandom_range(8000, 30000));
      load_setting(lo, 16'(lo + $urandom_range(512, 25000)), 16'($urandom_range(0, 400)),
                   16'($urandom_range(0, 3000)), 16'($urandom_range(0, 255)),
                   16'($urandom_range(0, 255)));
      queue_random(55);
      drain();
    end

    repeat (200) @(posedge clk);
    $display("Checked %0d drive beats from %0d pulse beats over %0d register settings",
             drives_seen, beats_taken, phase_cnt + 1);
    $display("Mismatches: %0d", mismatch_cnt);
    if (mismatch_cnt == 0 && drive_exp_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== rc_differential_drive_mixer_top.f =====
+incdir+rtl
rtl/rcdm_pkg.sv
rtl/rcdm_if.sv
rtl/rcdm_div.sv
rtl/rc_differential_drive_mixer_top.sv
verif/rc_differential_drive_mixer_top_test.sv
